@@ rtl/core/sbcf_pkg.sv @@
package sbcf_pkg;

    // Default geometry
    localparam int SHEET_WIDTH_DEF = 128;
    localparam int SHEET_ROWS_DEF  = 128;
    localparam int SPRITE_SIZE_DEF = 8;
    localparam int DEST_PITCH_DEF  = 148;

    // Fixed field widths
    localparam int SHEET_ADDR_W = 14;
    localparam int PIXEL_W      = 8;
    localparam int SRC_W        = 8;
    localparam int DEST_W       = 10;
    localparam int COLOR_W      = 4;
    localparam int DADDR_W      = 17;
    localparam int PAL_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // Signed width for clipping arithmetic; covers every intermediate value
    localparam int CW = 13;

    // Register reset values
    localparam logic [PAL_W-1:0] PALETTE_RESET = 64'hFEDC_BA98_7654_3210;
    localparam logic [7:0] CLIP_X_RESET       = 8'd0;
    localparam logic [7:0] CLIP_Y_RESET       = 8'd0;
    localparam logic [7:0] CLIP_W_RESET       = 8'd148;
    localparam logic [7:0] CLIP_H_RESET       = 8'd128;
    localparam logic [7:0] SHEET_HEIGHT_RESET = 8'd64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_X       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_Y       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_W       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_H       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHEET_HEIGHT = 3'd5;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRC   = 6'b000010,
        S_LT    = 6'b000100,
        S_RB    = 6'b001000,
        S_SETUP = 6'b010000,
        S_RUN   = 6'b100000
    } t_state;

endpackage

@@ rtl/core/sbcf_ram.sv @@
module sbcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/sprite_blitter_clip_flip.sv @@
// Channel   Direction  Handshake                  Payload
// in        sink       i_in_valid / o_in_ready    op, sheet_addr, sheet_pixel, src_x, src_y,
//                                                 dest_x, dest_y, fill_color, flip_x
// out       source     o_out_valid / i_out_ready  pixel_addr, pixel_color, write_enable, last
// cfg       sink       i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// A load's transfer writes the sheet RAM directly.
// A draw is its transfer, four clipping/setup steps (S_SRC, S_LT, S_RB, S_SETUP), then one
// sheet RAM read per visited pixel; the single RAM read port sets the pixel rate.
// A draw clipped to nothing returns to idle after S_SETUP and produces no transfer.
// Synchronous active-low reset clears control and config; the sheet RAM is not cleared.
// A stall on out freezes the pixel walk and the RAM read register; no pixel is dropped.
module sprite_blitter_clip_flip #(
    parameter int SHEET_WIDTH = sbcf_pkg::SHEET_WIDTH_DEF,
    parameter int SHEET_ROWS  = sbcf_pkg::SHEET_ROWS_DEF,
    parameter int SPRITE_SIZE = sbcf_pkg::SPRITE_SIZE_DEF,
    parameter int DEST_PITCH  = sbcf_pkg::DEST_PITCH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic                                    i_op,
    input  logic        [sbcf_pkg::SHEET_ADDR_W-1:0] i_sheet_addr,
    input  logic        [sbcf_pkg::PIXEL_W-1:0]      i_sheet_pixel,
    input  logic signed [sbcf_pkg::SRC_W-1:0]        i_src_x,
    input  logic signed [sbcf_pkg::SRC_W-1:0]        i_src_y,
    input  logic signed [sbcf_pkg::DEST_W-1:0]       i_dest_x,
    input  logic signed [sbcf_pkg::DEST_W-1:0]       i_dest_y,
    input  logic        [sbcf_pkg::COLOR_W-1:0]      i_fill_color,
    input  logic                                    i_flip_x,

    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic        [sbcf_pkg::DADDR_W-1:0]      o_pixel_addr,
    output logic        [sbcf_pkg::COLOR_W-1:0]      o_pixel_color,
    output logic                                    o_write_enable,
    output logic                                    o_last,

    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic        [sbcf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic        [sbcf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import sbcf_pkg::*;

    localparam int MEM_DEPTH = SHEET_WIDTH * SHEET_ROWS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int COL_AW    = $clog2(SHEET_WIDTH);
    localparam int CNT_W     = $clog2(SPRITE_SIZE + 1);

    localparam logic signed [CW-1:0] SS_S = CW'(SPRITE_SIZE);
    localparam logic signed [CW-1:0] SW_S = CW'(SHEET_WIDTH);

    // ---------------------------------------------------------------
    // Configuration registers (the user writes them only while idle; not enforced)
    // ---------------------------------------------------------------
    logic [PAL_W-1:0] r_palette;
    logic [7:0]       r_clip_x, r_clip_y, r_clip_w, r_clip_h, r_sheet_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette      <= PALETTE_RESET;
            r_clip_x       <= CLIP_X_RESET;
            r_clip_y       <= CLIP_Y_RESET;
            r_clip_w       <= CLIP_W_RESET;
            r_clip_h       <= CLIP_H_RESET;
            r_sheet_height <= SHEET_HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PALETTE:      r_palette      <= i_cfg_data;
                CFG_CLIP_X:       r_clip_x       <= i_cfg_data[7:0];
                CFG_CLIP_Y:       r_clip_y       <= i_cfg_data[7:0];
                CFG_CLIP_W:       r_clip_w       <= i_cfg_data[7:0];
                CFG_CLIP_H:       r_clip_h       <= i_cfg_data[7:0];
                CFG_SHEET_HEIGHT: r_sheet_height <= i_cfg_data[7:0];
                default: begin
                    // unmapped index: transfer taken, nothing stored
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic in_xfer, is_load, is_draw;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign is_load    = in_xfer && (i_op == OP_LOAD);
    assign is_draw    = in_xfer && (i_op == OP_DRAW);

    // Clipping geometry, signed
    logic signed [CW-1:0] r_sx, r_sy, r_px, r_py, r_w, r_h;
    logic                 r_flip;
    logic [COLOR_W-1:0]   r_fill;

    // Pixel walk
    logic [CNT_W-1:0]   r_x, r_y, r_wn, r_hn;
    logic [COL_AW-1:0]  r_col, r_col_start;
    logic [MEM_AW-1:0]  r_src_base;
    logic [DADDR_W-1:0] r_dst_base;

    // RAM read stage and output register
    logic               r_p1_valid, r_p1_last;
    logic [DADDR_W-1:0] r_p1_addr;
    logic [COLOR_W-1:0] r_p1_fill;
    logic               r_o_valid, r_o_we, r_o_last;
    logic [DADDR_W-1:0] r_o_addr;
    logic [COLOR_W-1:0] r_o_color;

    // ---------------------------------------------------------------
    // Clipping arithmetic: one group for S_SRC, one shared by S_LT and S_RB
    // ---------------------------------------------------------------
    logic signed [CW-1:0] sx_a, px_a, w_a, sy_a, py_a, h_a;
    logic signed [CW-1:0] w_src, h_src, rows_s;
    logic [8:0]           rows_u;
    logic signed [CW-1:0] cx_s, cy_s, dx, dy, limx, limy;

    always_comb begin
        // sheet clip: negative source shifts the destination
        if (r_sx < 0) begin
            sx_a = '0;
            w_a  = SS_S + r_sx;
            px_a = r_px - r_sx;
        end else begin
            sx_a = r_sx;
            w_a  = SS_S;
            px_a = r_px;
        end
        if (r_sy < 0) begin
            sy_a = '0;
            h_a  = SS_S + r_sy;
            py_a = r_py - r_sy;
        end else begin
            sy_a = r_sy;
            h_a  = SS_S;
            py_a = r_py;
        end
        rows_u = ({1'b0, r_sheet_height} > 9'(SHEET_ROWS)) ? 9'(SHEET_ROWS)
                                                          : {1'b0, r_sheet_height};
        rows_s = $signed(CW'(rows_u));
        w_src  = ((SW_S - sx_a) < w_a) ? (SW_S - sx_a) : w_a;
        h_src  = ((rows_s - sy_a) < h_a) ? (rows_s - sy_a) : h_a;

        // clip rectangle
        cx_s = $signed(CW'(r_clip_x));
        cy_s = $signed(CW'(r_clip_y));
        dx   = cx_s - r_px;
        dy   = cy_s - r_py;
        limx = cx_s + $signed(CW'(r_clip_w)) - r_px;
        limy = cy_s + $signed(CW'(r_clip_h)) - r_py;
    end

    // ---------------------------------------------------------------
    // Pixel walk and RAM access
    // ---------------------------------------------------------------
    logic              out_free, p1_move, issue, x_end, y_end;
    logic [MEM_AW-1:0] src_addr;
    logic [PIXEL_W-1:0] ram_q;

    assign out_free = !r_o_valid || i_out_ready;
    assign p1_move  = r_p1_valid && out_free;
    assign issue    = (r_state == S_RUN) && (!r_p1_valid || out_free);
    assign x_end    = (r_x == r_wn - CNT_W'(1));
    assign y_end    = (r_y == r_hn - CNT_W'(1));
    assign src_addr = r_src_base + MEM_AW'(r_col);

    sbcf_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MEM_DEPTH)
    ) u_sheet (
        .i_clk   (i_clk),
        .i_we    (is_load && (32'(i_sheet_addr) < MEM_DEPTH)),
        .i_waddr (MEM_AW'(i_sheet_addr)),
        .i_wdata (i_sheet_pixel),
        .i_re    (issue),
        .i_raddr (src_addr),
        .o_rdata (ram_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (is_draw) n_state = S_SRC;
            S_SRC:   n_state = S_LT;
            S_LT:    n_state = S_RB;
            S_RB:    n_state = S_SETUP;
            S_SETUP: n_state = (r_w <= 0 || r_h <= 0) ? S_IDLE : S_RUN;
            S_RUN:   if (issue && x_end && y_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_p1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (issue) begin
                r_p1_valid <= 1'b1;
            end else if (p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_move) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload and datapath registers
    logic               pix_we;
    logic [COLOR_W-1:0] pal_idx, pix_color;

    always_comb begin
        pix_we    = (ram_q != '0);
        pal_idx   = (r_p1_fill != '0) ? r_p1_fill : ram_q[COLOR_W-1:0];
        pix_color = pix_we ? r_palette[{pal_idx, 2'b00} +: COLOR_W] : '0;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (is_draw) begin
                    r_sx   <= CW'(i_src_x);
                    r_sy   <= CW'(i_src_y);
                    r_px   <= CW'(i_dest_x);
                    r_py   <= CW'(i_dest_y);
                    r_fill <= i_fill_color;
                    r_flip <= i_flip_x;
                end
            end
            S_SRC: begin
                r_sx <= sx_a;
                r_sy <= sy_a;
                r_px <= px_a;
                r_py <= py_a;
                r_w  <= w_src;
                r_h  <= h_src;
            end
            S_LT: begin
                if (dx > 0) begin
                    r_w  <= r_w - dx;
                    r_sx <= r_sx + dx;
                    r_px <= cx_s;
                end
                if (dy > 0) begin
                    r_h  <= r_h - dy;
                    r_sy <= r_sy + dy;
                    r_py <= cy_s;
                end
            end
            S_RB: begin
                if (r_w > limx) r_w <= limx;
                if (r_h > limy) r_h <= limy;
            end
            S_SETUP: begin
                // only meaningful when the rectangle is not empty
                r_wn        <= r_w[CNT_W-1:0];
                r_hn        <= r_h[CNT_W-1:0];
                r_x         <= '0;
                r_y         <= '0;
                r_col_start <= r_flip ? COL_AW'(r_sx + r_w - CW'(1)) : COL_AW'(r_sx);
                r_col       <= r_flip ? COL_AW'(r_sx + r_w - CW'(1)) : COL_AW'(r_sx);
                r_src_base  <= MEM_AW'(32'(r_sy) * SHEET_WIDTH);
                r_dst_base  <= DADDR_W'(32'(r_px) + 32'(r_py) * DEST_PITCH);
            end
            S_RUN: begin
                if (issue) begin
                    if (x_end) begin
                        r_x        <= '0;
                        r_y        <= r_y + CNT_W'(1);
                        r_col      <= r_col_start;
                        r_src_base <= r_src_base + MEM_AW'(SHEET_WIDTH);
                        r_dst_base <= r_dst_base + DADDR_W'(DEST_PITCH);
                    end else begin
                        r_x   <= r_x + CNT_W'(1);
                        r_col <= r_flip ? r_col - COL_AW'(1) : r_col + COL_AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase

        if (issue) begin
            r_p1_addr <= r_dst_base + DADDR_W'(r_x);
            r_p1_last <= x_end && y_end;
            r_p1_fill <= r_fill;
        end
        if (p1_move) begin
            r_o_addr  <= r_p1_addr;
            r_o_color <= pix_color;
            r_o_we    <= pix_we;
            r_o_last  <= r_p1_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_pixel_addr   = r_o_addr;
    assign o_pixel_color  = r_o_color;
    assign o_write_enable = r_o_we;
    assign o_last         = r_o_last;

`ifndef ASSERT_OFF
    // every sheet read stays inside the sheet after clipping
    a_read_in_sheet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (32'(src_addr) < MEM_DEPTH))
        else $error("sheet read outside the sheet");

    // walk counters stay inside the clipped rectangle
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((r_x < r_wn) && (r_y < r_hn)))
        else $error("pixel walk left the clipped rectangle");

    // an issued read always lands in the read stage
    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_p1_valid)
        else $error("issued sheet read lost");

    // no new item is taken while the walk runs
    a_no_accept_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !in_xfer)
        else $error("input transfer during pixel walk");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import sbcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any transfer
    localparam int DRAIN_CYCLES   = 20;     // room for a trailing empty draw to finish
    localparam int SHEET_CELLS    = SHEET_WIDTH_DEF * SHEET_ROWS_DEF;
    localparam int IDLE_PCT       = 36;

    // One input transfer: load fields and draw fields travel together.
    typedef struct {
        logic                   op;
        logic [SHEET_ADDR_W-1:0] sheet_addr;
        logic [PIXEL_W-1:0]     sheet_pixel;
        logic signed [SRC_W-1:0]  src_x;
        logic signed [SRC_W-1:0]  src_y;
        logic signed [DEST_W-1:0] dest_x;
        logic signed [DEST_W-1:0] dest_y;
        logic [COLOR_W-1:0]     fill_color;
        logic                   flip_x;
    } t_blit_item;

    // One output transfer.
    typedef struct {
        logic [DADDR_W-1:0] pixel_addr;
        logic [COLOR_W-1:0] pixel_color;
        logic               write_enable;
        logic               last_px;
    } t_px_result;

    // Clipped walk rectangle: size, source corner, destination corner.
    typedef struct {
        int w;
        int h;
        int sx;
        int sy;
        int px;
        int py;
    } t_blit_rect;

    // ------------------------------------------------------------------
    // Clock, reset and DUT-facing signals (those the bench drives are known from time 0)
    // ------------------------------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic                     op          = OP_LOAD;
    logic [SHEET_ADDR_W-1:0]  sheet_addr  = '0;
    logic [PIXEL_W-1:0]       sheet_pixel = '0;
    logic signed [SRC_W-1:0]  src_x       = '0;
    logic signed [SRC_W-1:0]  src_y       = '0;
    logic signed [DEST_W-1:0] dest_x      = '0;
    logic signed [DEST_W-1:0] dest_y      = '0;
    logic [COLOR_W-1:0]       fill_color  = '0;
    logic                     flip_x      = 1'b0;

    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [DADDR_W-1:0]       pixel_addr;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     write_enable;
    logic                     last_flag;

    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index   = CFG_PALETTE;
    logic [CFG_DATA_W-1:0]    cfg_data    = '0;

    sprite_blitter_clip_flip uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (op),
        .i_sheet_addr   (sheet_addr),
        .i_sheet_pixel  (sheet_pixel),
        .i_src_x        (src_x),
        .i_src_y        (src_y),
        .i_dest_x       (dest_x),
        .i_dest_y       (dest_y),
        .i_fill_color   (fill_color),
        .i_flip_x       (flip_x),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_addr   (pixel_addr),
        .o_pixel_color  (pixel_color),
        .o_write_enable (write_enable),
        .o_last         (last_flag),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: registers and sheet contents as seen by the
    // transfers that actually happened.
    // ------------------------------------------------------------------
    logic [PAL_W-1:0] palette_m = PALETTE_RESET;
    int clip_x_m  = int'(CLIP_X_RESET);
    int clip_y_m  = int'(CLIP_Y_RESET);
    int clip_w_m  = int'(CLIP_W_RESET);
    int clip_h_m  = int'(CLIP_H_RESET);
    int sheet_h_m = int'(SHEET_HEIGHT_RESET);

    logic [PIXEL_W-1:0] sheet_model [SHEET_CELLS];
    // Stimulus-side record of written cells; draws never touch the others.
    bit                 sheet_loaded [SHEET_CELLS];

    t_blit_item pending_items[$];
    t_px_result expected_pixels[$];
    t_blit_item next_item;
    t_blit_item seen_item;
    t_px_result want;

    int  items_outstanding = 0;   // queued but not yet transferred
    int  items_queued      = 0;   // every input item ever queued
    int  fail_count        = 0;
    int  quiet_cycles      = 0;
    bit  steady            = 1'b0; // no idling on either side
    bit  in_acc            = 1'b0;
    bit  out_acc           = 1'b0;
    bit  cfg_acc           = 1'b0;
    bit  cfg_taken         = 1'b0;

    // Source clip against the sheet, then destination clip against the
    // clip rectangle. A negative source corner pushes the destination.
    function automatic t_blit_rect clipped_area(input int sx, input int sy,
                                                input int px, input int py);
        t_blit_rect r;
        int rows;
        int d;
        r.w  = SPRITE_SIZE_DEF;
        r.h  = SPRITE_SIZE_DEF;
        rows = (sheet_h_m > SHEET_ROWS_DEF) ? SHEET_ROWS_DEF : sheet_h_m;
        if (sx < 0) begin
            r.w += sx; px -= sx; sx = 0;
        end
        if (SHEET_WIDTH_DEF - sx < r.w) r.w = SHEET_WIDTH_DEF - sx;
        if (sy < 0) begin
            r.h += sy; py -= sy; sy = 0;
        end
        if (rows - sy < r.h) r.h = rows - sy;
        d = clip_x_m - px;
        if (d > 0) begin
            r.w -= d; px += d; sx += d;
        end
        d = px + r.w - clip_x_m - clip_w_m;
        if (d > 0) r.w -= d;
        d = clip_y_m - py;
        if (d > 0) begin
            r.h -= d; py += d; sy += d;
        end
        d = py + r.h - clip_y_m - clip_h_m;
        if (d > 0) r.h -= d;
        r.sx = sx;
        r.sy = sy;
        r.px = px;
        r.py = py;
        return r;
    endfunction

    // Apply one input transfer to the shadow; a draw queues its pixels.
    task automatic blit_pixels(input t_blit_item it);
        t_blit_rect r;
        t_px_result res;
        logic [PIXEL_W-1:0] p;
        logic [COLOR_W-1:0] idx;
        int col;
        int sa;
        int da;
        if (it.op == OP_LOAD) begin
            sheet_model[it.sheet_addr] = it.sheet_pixel;
        end else begin
            r = clipped_area(it.src_x, it.src_y, it.dest_x, it.dest_y);
            for (int y = 0; y < r.h; y++) begin
                for (int x = 0; x < r.w; x++) begin
                    col = it.flip_x ? r.sx + (r.w - 1 - x) : r.sx + x;
                    sa  = col + (r.sy + y) * SHEET_WIDTH_DEF;
                    p   = sheet_model[sa];
                    // only the low nibble of a source pixel picks the entry
                    idx = (it.fill_color != '0) ? it.fill_color : p[COLOR_W-1:0];
                    res.write_enable = (p != '0);
                    res.pixel_color  = res.write_enable ? palette_m[4*idx +: 4] : '0;
                    da = (r.px + x) + (r.py + y) * DEST_PITCH_DEF;
                    res.pixel_addr = da[DADDR_W-1:0];
                    res.last_px    = (y == r.h - 1) && (x == r.w - 1);
                    expected_pixels.push_back(res);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_blit_item random_item();
        t_blit_item it;
        it.op          = 1'($urandom_range(0, 1));
        it.sheet_addr  = SHEET_ADDR_W'($urandom);
        it.sheet_pixel = PIXEL_W'($urandom);
        it.src_x       = SRC_W'($urandom);
        it.src_y       = SRC_W'($urandom);
        it.dest_x      = DEST_W'($urandom);
        it.dest_y      = DEST_W'($urandom);
        it.fill_color  = COLOR_W'($urandom);
        it.flip_x      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // about a quarter of sheet pixels transparent
    function automatic logic [PIXEL_W-1:0] rand_pixel();
        if ($urandom_range(0, 3) == 0) return '0;
        return PIXEL_W'($urandom_range(1, 255));
    endfunction

    function automatic int clamp_dest(input int v);
        if (v < -512) return -512;
        if (v > 511) return 511;
        return v;
    endfunction

    task automatic push_item(input t_blit_item it);
        pending_items.push_back(it);
        items_outstanding++;
        items_queued++;
    endtask

    task automatic queue_load(input int addr, input logic [PIXEL_W-1:0] pix);
        t_blit_item it;
        it             = random_item();
        it.op          = OP_LOAD;
        it.sheet_addr  = addr[SHEET_ADDR_W-1:0];
        it.sheet_pixel = pix;
        sheet_loaded[addr] = 1'b1;
        push_item(it);
    endtask

    // Queue a draw, preceded by loads for any source cell it would read
    // that has never been written.
    task automatic queue_draw(input int sx, input int sy, input int dx, input int dy,
                              input int fill, input int flip);
        t_blit_item it;
        t_blit_rect r;
        int sa;
        r = clipped_area(sx, sy, dx, dy);
        if (r.w > 0 && r.h > 0) begin
            for (int y = 0; y < r.h; y++) begin
                for (int x = 0; x < r.w; x++) begin
                    sa = r.sx + x + (r.sy + y) * SHEET_WIDTH_DEF;
                    if (!sheet_loaded[sa]) queue_load(sa, rand_pixel());
                end
            end
        end
        it            = random_item();
        it.op         = OP_DRAW;
        it.src_x      = sx[SRC_W-1:0];
        it.src_y      = sy[SRC_W-1:0];
        it.dest_x     = dx[DEST_W-1:0];
        it.dest_y     = dy[DEST_W-1:0];
        it.fill_color = fill[COLOR_W-1:0];
        it.flip_x     = flip[0];
        push_item(it);
    endtask

    // Random mix: mostly draws from the top-left corner of the sheet that
    // land in the clip rectangle, plus stray loads and draws with fully
    // random corners (mostly clipped away). Queues input items, preloads
    // included, until the budget is used up.
    task automatic random_items(input int budget);
        int r;
        int sx;
        int sy;
        int dx;
        int dy;
        int rows;
        int fill;
        int start;
        start = items_queued;
        while (items_queued - start < budget) begin
            r    = $urandom_range(0, 99);
            rows = (sheet_h_m > SHEET_ROWS_DEF) ? SHEET_ROWS_DEF : sheet_h_m;
            fill = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 15));
            if (r < 15) begin
                queue_load($urandom_range(0, SHEET_CELLS - 1), rand_pixel());
            end else if (r < 25) begin
                queue_draw(int'($urandom_range(0, 255)) - 128,
                           int'($urandom_range(0, 255)) - 128,
                           int'($urandom_range(0, 1023)) - 512,
                           int'($urandom_range(0, 1023)) - 512,
                           fill, $urandom_range(0, 1));
            end else begin
                // right edge of the sheet now and then
                if ($urandom_range(0, 9) == 0) sx = int'($urandom_range(124, 127));
                else sx = int'($urandom_range(0, 10)) - 6;
                // bottom of the rows in use now and then
                if ($urandom_range(0, 9) == 0) begin
                    sy = rows - int'($urandom_range(1, 5));
                    if (sy < -128) sy = -128;
                end else begin
                    sy = int'($urandom_range(0, 10)) - 6;
                end
                dx = clamp_dest(clip_x_m + int'($urandom_range(0, clip_w_m + 10)) - 9);
                dy = clamp_dest(clip_y_m + int'($urandom_range(0, clip_h_m + 10)) - 9);
                queue_draw(sx, sy, dx, dy, fill, $urandom_range(0, 1));
            end
        end
    endtask

    // Called at a falling edge; leaves the caller at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        cfg_taken = 1'b0;
        do @(negedge clk); while (!cfg_taken);
    endtask

    // Wait until every queued item went through and every pixel came out,
    // then give a trailing empty draw time to finish.
    task automatic wait_drained();
        do @(negedge clk); while (items_outstanding != 0 || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Byte registers get junk in the upper bits; only bits 7:0 count.
    task automatic new_phase(input logic [PAL_W-1:0] pal, input int cx, input int cy,
                             input int cw, input int ch, input int sh, input bit quiet);
        wait_drained();
        steady = quiet;
        write_reg(CFG_PALETTE, pal);
        write_reg(CFG_CLIP_X, {32'($urandom), 24'($urandom), 8'(cx)});
        write_reg(CFG_CLIP_Y, {32'($urandom), 24'($urandom), 8'(cy)});
        write_reg(CFG_CLIP_W, {32'($urandom), 24'($urandom), 8'(cw)});
        write_reg(CFG_CLIP_H, {32'($urandom), 24'($urandom), 8'(ch)});
        write_reg(CFG_SHEET_HEIGHT, {32'($urandom), 24'($urandom), 8'(sh)});
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Driver: inputs move on the falling edge. A held item stays put
    // until its transfer; ready on the result side toggles at random outside steady phases.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_acc) begin
            if (pending_items.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                next_item    = pending_items.pop_front();
                op          <= next_item.op;
                sheet_addr  <= next_item.sheet_addr;
                sheet_pixel <= next_item.sheet_pixel;
                src_x       <= next_item.src_x;
                src_y       <= next_item.src_y;
                dest_x      <= next_item.dest_x;
                dest_y      <= next_item.dest_y;
                fill_color  <= next_item.fill_color;
                flip_x      <= next_item.flip_x;
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: every transfer is taken on the rising edge.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        in_acc  = rst_n && in_valid && in_ready;
        out_acc = rst_n && out_valid && out_ready;
        cfg_acc = rst_n && cfg_valid && cfg_ready;

        if (cfg_acc) begin
            case (cfg_index)
                CFG_PALETTE:      palette_m = cfg_data;
                CFG_CLIP_X:       clip_x_m  = int'(cfg_data[7:0]);
                CFG_CLIP_Y:       clip_y_m  = int'(cfg_data[7:0]);
                CFG_CLIP_W:       clip_w_m  = int'(cfg_data[7:0]);
                CFG_CLIP_H:       clip_h_m  = int'(cfg_data[7:0]);
                CFG_SHEET_HEIGHT: sheet_h_m = int'(cfg_data[7:0]);
                default: ;
            endcase
            cfg_taken = 1'b1;
        end

        if (in_acc) begin
            seen_item.op          = op;
            seen_item.sheet_addr  = sheet_addr;
            seen_item.sheet_pixel = sheet_pixel;
            seen_item.src_x       = src_x;
            seen_item.src_y       = src_y;
            seen_item.dest_x      = dest_x;
            seen_item.dest_y      = dest_y;
            seen_item.fill_color  = fill_color;
            seen_item.flip_x      = flip_x;
            blit_pixels(seen_item);
            items_outstanding--;
        end

        if (out_acc) begin
            if (expected_pixels.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected pixel transfer: addr=%0d color=%0d we=%0b last=%0b",
                             pixel_addr, pixel_color, write_enable, last_flag);
            end else begin
                want = expected_pixels.pop_front();
                if (pixel_addr !== want.pixel_addr || pixel_color !== want.pixel_color ||
                    write_enable !== want.write_enable || last_flag !== want.last_px) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"pixel mismatch: exp addr=%0d color=%0d we=%0b last=%0b",
                                  " | got addr=%0d color=%0d we=%0b last=%0b"},
                                 want.pixel_addr, want.pixel_color, want.write_enable,
                                 want.last_px, pixel_addr, pixel_color, write_enable,
                                 last_flag);
                end
            end
        end

        // watchdog: a hang anywhere shows up as a long run with no transfer
        if (in_acc || out_acc || cfg_acc) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset settings: 148x128 clip, 64 sheet rows in use.
        queue_load(0, 8'hFF);                    // above 15: low nibble picks entry
        queue_load(SHEET_CELLS - 1, 8'h00);      // last cell, transparent
        queue_load(130, 8'h3A);
        queue_draw(0, 0, 0, 0, 0, 0);            // whole sprite at the origin
        queue_draw(0, 0, 20, 0, 0, 1);           // mirrored
        queue_draw(0, 0, 40, 0, 15, 1);          // fill colour, mirrored
        queue_draw(-3, -5, 10, 10, 0, 0);        // negative source shifts dest
        queue_draw(-2, 0, 30, 10, 0, 1);
        queue_draw(-128, -128, 0, 0, 0, 0);      // clipped to nothing
        queue_draw(127, 0, 60, 0, 0, 0);         // one column at the sheet edge
        queue_draw(120, 60, 70, 0, 0, 1);        // cut by sheet height
        queue_draw(0, 64, 0, 0, 0, 0);           // first row past the rows in use
        queue_draw(127, 127, 0, 0, 0, 0);
        queue_draw(0, 0, -512, -512, 0, 0);      // far outside the clip
        queue_draw(0, 0, 511, 511, 0, 0);
        queue_draw(0, 0, -4, -4, 3, 0);          // cut at left and top
        queue_draw(0, 0, 144, 124, 0, 1);        // cut at right and bottom
        queue_draw(0, 0, -7, 0, 0, 0);
        queue_draw(0, 60, 100, 50, 0, 0);
        queue_draw(-1, -1, -1, -1, 0, 0);
        queue_draw(4, 4, 80, 80, 9, 0);

        // Full sheet height, random palette.
        new_phase({32'($urandom), 32'($urandom)}, 0, 0, 148, 128, 128, 1'b0);
        queue_draw(124, 124, 0, 0, 0, 0);        // reaches the last sheet cell
        random_items(35);

        // Clip wider than the pitch, height beyond the sheet; no idling here.
        new_phase({PAL_W{1'b1}}, 0, 0, 255, 255, 255, 1'b1);
        queue_draw(124, 124, 250, 250, 0, 1);
        random_items(35);

        // Clip corner at the far extreme, one sheet row, palette all zero.
        new_phase('0, 255, 255, 255, 255, 1, 1'b0);
        random_items(20);

        // Empty clip and zero sheet height: every draw gives nothing.
        new_phase({32'($urandom), 32'($urandom)}, 0, 0, 0, 0, 0, 1'b0);
        random_items(10);

        // Small clip window inside the screen.
        new_phase({32'($urandom), 32'($urandom)}, 20, 10, 30, 25, 64, 1'b0);
        random_items(35);

        // Random settings.
        for (int k = 0; k < 3; k++) begin
            new_phase({32'($urandom), 32'($urandom)}, $urandom_range(0, 160),
                      $urandom_range(0, 160), $urandom_range(1, 255),
                      $urandom_range(1, 255), $urandom_range(1, 255), 1'b0);
            random_items(22);
        end

        wait_drained();
        if (fail_count == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sbcf_pkg.sv
rtl/core/sbcf_ram.sv
rtl/core/sprite_blitter_clip_flip.sv
tb/tb.sv
